FILE: rtl/bmprow_pkg.sv
package bmprow_pkg;

  // fixed field widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int BPP_W      = 6;
  localparam int DIM_W      = 13;
  localparam int COORD_W    = 12;
  localparam int RBC_W      = 15;
  localparam int ROW_BITS_W = 18;
  localparam int RGB_W      = 24;

  // largest image the counters are sized for
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // floor(x / 3) == (x * DIV3_RECIP) >> 16 for x below 2**15
  localparam int DIV3_RECIP = 21846;

  // register reset values
  localparam logic [BPP_W-1:0]      BPP_RST   = 6'd24;
  localparam logic [DIM_W-1:0]      DIM_RST   = 13'd1;
  localparam logic [CFG_DATA_W-1:0] RMASK_RST = 32'h00ff_0000;
  localparam logic [CFG_DATA_W-1:0] GMASK_RST = 32'h0000_ff00;
  localparam logic [CFG_DATA_W-1:0] BMASK_RST = 32'h0000_00ff;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BPP        = 3'd0,
    CFG_WIDTH      = 3'd1,
    CFG_HEIGHT     = 3'd2,
    CFG_TOP_DOWN   = 3'd3,
    CFG_BITFIELDS  = 3'd4,
    CFG_RED_MASK   = 3'd5,
    CFG_GREEN_MASK = 3'd6,
    CFG_BLUE_MASK  = 3'd7
  } cfg_reg_e;

  // item command codes
  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_DATA    = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] palette_red;
    logic [7:0] palette_green;
    logic [7:0] palette_blue;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_column;
    logic               last_of_item;
    logic               last_of_image;
  } out_word_t;

endpackage

FILE: rtl/bmp_pixel_row_unpacker.sv
// channel   direction  handshake              payload
// cfg       in         cfg_we                 cfg_index, cfg_data
// req       in         req_valid / req_ready  req (palette write or pixel-data byte)
// rsp       out        rsp_valid / rsp_ready  rsp (one pixel with row and column)
//
// A word taken waits in the job register, then passes to the output register.
// Bytes of 8/16/24/32-bit images are taken one per cycle unless the output stalls;
// a byte of a 1/2/4-bit image holds the job register while its pixels (up to 8) go
// one at a time through the single palette read port to a one-pixel output register.
// Synchronous reset restores the registers to defaults and clears the counters;
// the palette is not cleared. A low rsp_ready holds the output register, and
// req_ready stays high while the job register is free or drains this cycle.
module bmp_pixel_row_unpacker #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bmprow_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmprow_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  bmprow_pkg::in_word_t               req,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output bmprow_pkg::out_word_t              rsp
);
  import bmprow_pkg::*;

  localparam int PAL_AW = (PALETTE_DEPTH > 2) ? $clog2(PALETTE_DEPTH) : 1;

  typedef enum logic [2:0] {
    MODE_NONE, MODE_1, MODE_2, MODE_4, MODE_8, MODE_16, MODE_24, MODE_32
  } mode_t;

  typedef struct packed {
    logic               pal;
    logic [31:0]        word;
    logic [COORD_W-1:0] col;
    logic [2:0]         n_last;
    logic [COORD_W-1:0] row;
    logic               last_row;
  } job_t;

  typedef struct packed {
    logic               pal;
    logic               oob;
    logic [RGB_W-1:0]   rgb;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last_item;
    logic               last_img;
  } emit_t;

  // configuration registers
  logic [BPP_W-1:0]      bits_per_pixel;
  logic [DIM_W-1:0]      image_width;
  logic [DIM_W-1:0]      image_height;
  logic                  top_down;
  logic                  bitfields_mode;
  logic [CFG_DATA_W-1:0] red_mask;
  logic [CFG_DATA_W-1:0] green_mask;
  logic [CFG_DATA_W-1:0] blue_mask;

  // stream state
  logic [RGB_W-1:0]   byte_gather, byte_gather_next;
  logic [1:0]         byte_phase, byte_phase_next;
  logic [COORD_W-1:0] row_count, row_count_next;
  logic [RBC_W-1:0]   row_byte_count, row_byte_count_next;

  // job register, emitter and output register
  job_t               job, job_d;
  logic               job_valid;
  logic [2:0]         pix_idx;
  emit_t              s2, emit_d;
  logic               s2_valid;
  logic [RGB_W-1:0]   pal_mem [PALETTE_DEPTH];
  logic [RGB_W-1:0]   pal_q;

  // decoded configuration
  mode_t              mode;
  logic [1:0]         lg;
  logic               sub;
  logic [DIM_W-1:0]   w, h, wm1, hm1;
  logic [ROW_BITS_W-1:0] w_ext, bits_row, row_round, byte_round;
  logic [RBC_W-1:0]   row_size, data_bytes;

  // per-byte decode
  logic               accept, data_beat, in_data, job_load;
  logic [COORD_W-1:0] r, dest_row;
  logic               last_row;
  logic [ROW_BITS_W-1:0] base;
  logic [3:0]         per;
  logic               sub_has;
  logic [ROW_BITS_W-1:0] rem;
  logic [2:0]         sub_nlast;
  logic [2:0]         nb;
  logic               phase_hit;
  logic [2*RBC_W-1:0] prod3;
  logic [RBC_W-2:0]   col_m;
  logic               multi_has;
  logic [RBC_W-1:0]   rbc_inc;

  // emitter datapath
  logic               adv, job_done;
  logic [COORD_W-1:0] pix_col;
  logic [2:0]         shamt;
  logic [7:0]         byte_sh, rd_idx;
  logic               wr_ok;

  function automatic logic [7:0] mask_field(input logic [31:0] word,
                                            input logic [31:0] mask);
    logic [31:0] masked;
    logic [4:0]  tz;
    masked = word & mask;
    tz = '0;
    for (int k = 31; k >= 0; k--) begin
      if (mask[k]) tz = 5'(k);
    end
    mask_field = (mask == '0) ? 8'd0 : 8'(masked >> tz);
  endfunction

  // configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_pixel <= BPP_RST;
      image_width    <= DIM_RST;
      image_height   <= DIM_RST;
      top_down       <= 1'b0;
      bitfields_mode <= 1'b0;
      red_mask       <= RMASK_RST;
      green_mask     <= GMASK_RST;
      blue_mask      <= BMASK_RST;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        CFG_BPP:        bits_per_pixel <= cfg_data[BPP_W-1:0];
        CFG_WIDTH:      image_width    <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT:     image_height   <= cfg_data[DIM_W-1:0];
        CFG_TOP_DOWN:   top_down       <= cfg_data[0];
        CFG_BITFIELDS:  bitfields_mode <= cfg_data[0];
        CFG_RED_MASK:   red_mask       <= cfg_data;
        CFG_GREEN_MASK: green_mask     <= cfg_data;
        CFG_BLUE_MASK:  blue_mask      <= cfg_data;
        default: ;
      endcase
    end
  end

  // depth decode
  always_comb begin
    mode = MODE_NONE;
    lg   = 2'd0;
    case (bits_per_pixel)
      6'd1:  begin mode = MODE_1;  lg = 2'd0; end
      6'd2:  begin mode = MODE_2;  lg = 2'd1; end
      6'd4:  begin mode = MODE_4;  lg = 2'd2; end
      6'd8:  begin mode = MODE_8;  lg = 2'd3; end
      6'd16: mode = MODE_16;
      6'd24: mode = MODE_24;
      6'd32: mode = MODE_32;
      default: mode = MODE_NONE;
    endcase
  end

  assign sub = (mode == MODE_1) || (mode == MODE_2) || (mode == MODE_4) ||
               (mode == MODE_8);

  // clamped dimensions and row geometry
  always_comb begin
    if (image_width == '0) w = DIM_W'(1);
    else if (image_width > DIM_W'(MAX_WIDTH)) w = DIM_W'(MAX_WIDTH);
    else w = image_width;
    if (image_height == '0) h = DIM_W'(1);
    else if (image_height > DIM_W'(MAX_HEIGHT)) h = DIM_W'(MAX_HEIGHT);
    else h = image_height;
  end

  assign wm1   = w - DIM_W'(1);
  assign hm1   = h - DIM_W'(1);
  assign w_ext = ROW_BITS_W'(w);

  always_comb begin
    case (mode)
      MODE_2:  bits_row = w_ext << 1;
      MODE_4:  bits_row = w_ext << 2;
      MODE_8:  bits_row = w_ext << 3;
      MODE_16: bits_row = w_ext << 4;
      MODE_24: bits_row = (w_ext << 4) + (w_ext << 3);
      MODE_32: bits_row = w_ext << 5;
      default: bits_row = w_ext;
    endcase
  end

  assign row_round  = bits_row + ROW_BITS_W'(31);
  assign byte_round = bits_row + ROW_BITS_W'(7);
  assign row_size   = {row_round[ROW_BITS_W-1:5], 2'b00};
  assign data_bytes = byte_round[ROW_BITS_W-1:3];

  // destination row
  assign r        = ({1'b0, row_count} < h) ? row_count : hm1[COORD_W-1:0];
  assign dest_row = top_down ? r : COORD_W'(hm1 - {1'b0, r});
  assign last_row = ({1'b0, r} == hm1);

  // input handshake
  assign adv       = job_valid && (!s2_valid || rsp_ready);
  assign job_done  = adv && (pix_idx == job.n_last);
  assign req_ready = !job_valid || job_done;
  assign accept    = req_valid && req_ready;
  assign data_beat = accept && (req.cmd == CMD_DATA) && (mode != MODE_NONE);
  assign in_data   = row_byte_count < data_bytes;

  // sub-byte pixels of this byte that fall inside the row
  assign per       = 4'd8 >> lg;
  assign base      = ROW_BITS_W'(row_byte_count) << (2'd3 - lg);
  assign sub_has   = base < w_ext;
  assign rem       = w_ext - base;
  assign sub_nlast = (rem >= ROW_BITS_W'(per)) ? 3'(per - 4'd1) : 3'(rem - ROW_BITS_W'(1));

  // multi-byte pixel completion and its column
  always_comb begin
    case (mode)
      MODE_16: nb = 3'd2;
      MODE_24: nb = 3'd3;
      default: nb = 3'd4;
    endcase
  end

  assign phase_hit = ({1'b0, byte_phase} + 3'd1) >= nb;
  assign prod3     = row_byte_count * RBC_W'(DIV3_RECIP);

  always_comb begin
    case (mode)
      MODE_16: col_m = row_byte_count[RBC_W-1:1];
      MODE_24: col_m = prod3[16 +: RBC_W-1];
      default: col_m = (RBC_W-1)'(row_byte_count >> 2);
    endcase
  end

  assign multi_has = phase_hit && (col_m < (RBC_W-1)'(w));
  assign job_load  = data_beat && in_data && (sub ? sub_has : multi_has);

  always_comb begin
    job_d.pal      = sub;
    job_d.word     = {req.data_byte, byte_gather};
    job_d.col      = sub ? base[COORD_W-1:0] : col_m[COORD_W-1:0];
    job_d.n_last   = sub ? sub_nlast : 3'd0;
    job_d.row      = dest_row;
    job_d.last_row = last_row;
  end

  // byte gathering and row/byte counters
  assign rbc_inc = row_byte_count + RBC_W'(1);

  always_comb begin
    byte_gather_next    = byte_gather;
    byte_phase_next     = byte_phase;
    row_count_next      = row_count;
    row_byte_count_next = rbc_inc;
    if (in_data && !sub) begin
      if (phase_hit) begin
        byte_gather_next = '0;
        byte_phase_next  = '0;
      end else begin
        byte_gather_next = byte_gather | (RGB_W'(req.data_byte) << {byte_phase, 3'b000});
        byte_phase_next  = byte_phase + 2'd1;
      end
    end
    if (rbc_inc >= row_size) begin
      row_byte_count_next = '0;
      byte_gather_next    = '0;
      byte_phase_next     = '0;
      row_count_next      = (({1'b0, row_count} + DIM_W'(1)) >= h) ? '0
                                                                    : row_count + COORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_gather    <= '0;
      byte_phase     <= '0;
      row_count      <= '0;
      row_byte_count <= '0;
    end else if (data_beat) begin
      byte_gather    <= byte_gather_next;
      byte_phase     <= byte_phase_next;
      row_count      <= row_count_next;
      row_byte_count <= row_byte_count_next;
    end
  end

  // job register and pixel index
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      pix_idx   <= '0;
    end else begin
      if (job_load) begin
        job_valid <= 1'b1;
        pix_idx   <= '0;
      end else if (job_done) begin
        job_valid <= 1'b0;
        pix_idx   <= '0;
      end else if (adv) begin
        pix_idx   <= pix_idx + 3'd1;
      end
    end
    if (job_load) job <= job_d;
  end

  // palette index of the current pixel, most significant first
  assign shamt   = 3'({2'b00, pix_idx} << lg);
  assign byte_sh = job.word[31:24] << shamt;

  always_comb begin
    case (lg)
      2'd0:    rd_idx = {7'd0, byte_sh[7]};
      2'd1:    rd_idx = {6'd0, byte_sh[7:6]};
      2'd2:    rd_idx = {4'd0, byte_sh[7:4]};
      default: rd_idx = byte_sh;
    endcase
  end

  // direct color and pixel tags
  assign pix_col = job.col + COORD_W'(pix_idx);

  always_comb begin
    emit_d.pal       = job.pal;
    emit_d.oob       = 32'(rd_idx) >= 32'(PALETTE_DEPTH);
    emit_d.row       = job.row;
    emit_d.col       = pix_col;
    emit_d.last_item = (pix_idx == job.n_last);
    emit_d.last_img  = job.last_row && (pix_col == wm1[COORD_W-1:0]);
    case (mode)
      MODE_16: emit_d.rgb = {1'b0, job.word[30:26], 2'b00,
                             1'b0, job.word[25:24], job.word[7:5], 2'b00,
                             1'b0, job.word[4:0], 2'b00};
      MODE_24: emit_d.rgb = {job.word[31:24], job.word[15:0]};
      MODE_32: emit_d.rgb = bitfields_mode ? {mask_field(job.word, red_mask),
                                              mask_field(job.word, green_mask),
                                              mask_field(job.word, blue_mask)}
                                           : job.word[23:0];
      default: emit_d.rgb = '0;
    endcase
  end

  // palette store: written by palette words, read by the emitter
  assign wr_ok = accept && (req.cmd == CMD_PALETTE) &&
                 (32'(req.palette_index) < 32'(PALETTE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      pal_mem[req.palette_index[PAL_AW-1:0]] <= {req.palette_red, req.palette_green,
                                                 req.palette_blue};
    end
    if (adv) pal_q <= pal_mem[rd_idx[PAL_AW-1:0]];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= 1'b1;
    end else if (rsp_ready) begin
      s2_valid <= 1'b0;
    end
    if (adv) s2 <= emit_d;
  end

  logic [RGB_W-1:0] rsp_rgb;
  assign rsp_rgb = s2.pal ? (s2.oob ? '0 : pal_q) : s2.rgb;

  assign rsp_valid          = s2_valid;
  assign rsp.red            = rsp_rgb[23:16];
  assign rsp.green          = rsp_rgb[15:8];
  assign rsp.blue           = rsp_rgb[7:0];
  assign rsp.pixel_row      = s2.row;
  assign rsp.pixel_column   = s2.col;
  assign rsp.last_of_item   = s2.last_item;
  assign rsp.last_of_image  = s2.last_img;

endmodule
